// File: rtl/ttb_pkg.sv
package ttb_pkg;

  // bank size default
  localparam int unsigned DEF_CHANNELS = 8;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TPU_W   = 10;
  localparam int unsigned MASK_W  = 8;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 10;

  // register reset values
  localparam logic [TPU_W-1:0]  TPU_RESET = 10'd100;
  localparam logic [MASK_W-1:0] ADM_RESET = 8'd0;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_DISABLE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_DISABLE   = 4'd1;

endpackage

// File: rtl/timeout_timer_bank.sv
// Bank of CHANNELS one-shot timeout channels. A tick transaction (tuser = tick) advances a
// prescaler, and every ticks_per_unit ticks the 32-bit time-unit counter steps by one; the
// tick then checks every channel through one shared subtract-and-compare unit, one channel
// per cycle, before the finish state hands on its result. Start, disable and query touch
// a single channel and go straight to the finish state. The input side is ready only while
// the sequencer is idle; it becomes idle again once the result has moved into the output
// register, so a new item may be taken while a finished result waits for out_tready.
// Every input transaction gives exactly one result transaction. Configuration writes are
// always accepted and are meant to be made only while the bank is idle.
module timeout_timer_bank #(
  parameter int unsigned CHANNELS = ttb_pkg::DEF_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: channel [2:0], duration_units [34:3], zero pad
  input  logic [ttb_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: opcode [1:0]
  input  logic [ttb_pkg::OP_W-1:0]         in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: start_stamp [31:0], start_accepted [32], chan_enabled [33],
  // chan_timed_out [34], expired_map [42:35], present_time [74:43], zero pad
  output logic [ttb_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import ttb_pkg::*;

  localparam int unsigned IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MAP_N   = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
  localparam int unsigned PAD_W   = OUT_DATA_W - (2 * TIME_W + 3 + MASK_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t                 state_r;
  logic [TPU_W-1:0]       tpu_r;
  logic [MASK_W-1:0]      adm_r;
  logic [TPU_W-1:0]       phase_r;
  logic [TIME_W-1:0]      time_r;
  logic [CHANNELS-1:0]    on_r;
  logic [CHANNELS-1:0]    exp_r;
  logic [TIME_W-1:0]      begin_r  [CHANNELS];
  logic [TIME_W-1:0]      length_r [CHANNELS];
  logic [IDX_W-1:0]       sweep_r;
  logic [CHAN_W-1:0]      ch_r;
  logic                   ch_ok_r;
  logic [TIME_W-1:0]      stamp_r;
  logic                   acc_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic                   in_fire;
  op_t                    in_op;
  logic [CHAN_W-1:0]      in_ch;
  logic [TIME_W-1:0]      in_dur;
  logic                   in_ch_ok;
  logic [IDX_W-1:0]       in_idx;
  logic [IDX_W-1:0]       ch_idx;
  logic [TPU_W-1:0]       limit;
  logic [TPU_W:0]         phase_inc;
  logic                   unit_wrap;
  logic [TPU_W-1:0]       phase_nxt;
  logic [TIME_W-1:0]      time_nxt;
  logic [TIME_W-1:0]      elapsed;
  logic                   chan_hit;
  logic [CHANNELS-1:0]    auto_vec;
  logic [MASK_W-1:0]      map_vec;
  logic                   res_en;
  logic                   res_tmo;
  logic                   out_free;

  // input decode
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser);
  assign in_ch     = in_tdata[CHAN_W-1:0];
  assign in_dur    = in_tdata[CHAN_W +: TIME_W];
  assign in_ch_ok  = (32'(in_ch) < CHANNELS);
  assign in_idx    = IDX_W'(in_ch);
  assign ch_idx    = IDX_W'(ch_r);

  assign cfg_ready = 1'b1;

  // prescaler and time-unit counter
  always_comb begin
    limit     = (tpu_r == '0) ? TPU_W'(1) : tpu_r;
    phase_inc = {1'b0, phase_r} + (TPU_W+1)'(1);
    unit_wrap = (phase_inc >= {1'b0, limit});
    phase_nxt = unit_wrap ? '0 : phase_inc[TPU_W-1:0];
    time_nxt  = time_r + TIME_W'(unit_wrap);
  end

  // per-channel auto-clear bit, only the first eight channels have one
  for (genvar c = 0; c < CHANNELS; c++) begin : g_auto
    if (c < MASK_W) begin : g_has
      assign auto_vec[c] = adm_r[c];
    end else begin : g_none
      assign auto_vec[c] = 1'b0;
    end
  end

  // expired map over the first eight channels
  always_comb begin
    map_vec = '0;
    for (int c = 0; c < MAP_N; c++) begin
      map_vec[c] = on_r[c] && exp_r[c];
    end
  end

  // shared elapsed-time compare for the swept channel
  assign elapsed  = time_r - begin_r[sweep_r];
  assign chan_hit = on_r[sweep_r] && !exp_r[sweep_r] && (elapsed >= length_r[sweep_r]);

  // addressed channel status after the operation
  assign res_en   = ch_ok_r && on_r[ch_idx];
  assign res_tmo  = ch_ok_r && on_r[ch_idx] && exp_r[ch_idx];
  assign out_free = !out_valid_r || out_tready;

  // channel timing and stamp storage, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_START && in_ch_ok && !on_r[in_idx]) begin
      begin_r[in_idx]  <= time_r;
      length_r[in_idx] <= in_dur;
    end
  end

  // sequencer, channel flags, registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tpu_r       <= TPU_RESET;
      adm_r       <= ADM_RESET;
      phase_r     <= '0;
      time_r      <= '0;
      on_r        <= '0;
      exp_r       <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        if (cfg_index == REG_TICKS_PER_UNIT) begin
          tpu_r <= cfg_data[TPU_W-1:0];
        end else if (cfg_index == REG_AUTO_DISABLE) begin
          adm_r <= cfg_data[MASK_W-1:0];
        end
      end

      // output valid: load from the sequencer or drain to the receiver
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            ch_r    <= in_ch;
            ch_ok_r <= in_ch_ok;
            stamp_r <= '0;
            acc_r   <= 1'b0;
            unique case (in_op)
              OP_TICK: begin
                phase_r <= phase_nxt;
                time_r  <= time_nxt;
                sweep_r <= '0;
                state_r <= ST_SWEEP;
              end
              OP_START: begin
                if (in_ch_ok && !on_r[in_idx]) begin
                  on_r[in_idx]  <= 1'b1;
                  exp_r[in_idx] <= 1'b0;
                  stamp_r       <= time_r;
                  acc_r         <= 1'b1;
                end
                state_r <= ST_FINISH;
              end
              OP_DISABLE: begin
                if (in_ch_ok) begin
                  on_r[in_idx]  <= 1'b0;
                  exp_r[in_idx] <= 1'b0;
                end
                state_r <= ST_FINISH;
              end
              OP_QUERY: begin
                state_r <= ST_FINISH;
              end
              default: state_r <= ST_FINISH;
            endcase
          end
        end

        // one channel per cycle through the shared compare
        ST_SWEEP: begin
          if (chan_hit) begin
            if (auto_vec[sweep_r]) begin
              on_r[sweep_r]  <= 1'b0;
              exp_r[sweep_r] <= 1'b0;
            end else begin
              exp_r[sweep_r] <= 1'b1;
            end
          end
          if (sweep_r == IDX_W'(CHANNELS - 1)) begin
            state_r <= ST_FINISH;
          end else begin
            sweep_r <= sweep_r + IDX_W'(1);
          end
        end

        // hand the result to the output register
        ST_FINISH: begin
          if (out_free) begin
            out_data_r  <= {PAD_W'(0), time_r, map_vec, res_tmo, res_en, acc_r, stamp_r};
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an expired flag only ever stands on an enabled channel
  a_exp_on: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r & ~on_r) == '0)
    else $error("expired flag set on a disabled channel");

  // the time-unit counter moves only on an accepted tick
  a_time_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && time_r != $past(time_r)) |->
      $past(in_fire && in_op == OP_TICK))
    else $error("time counter moved without a tick");

  // a timed-out report always comes with an enabled report
  a_tmo_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r[TIME_W+2] || out_data_r[TIME_W+1]))
    else $error("timed out reported on a disabled channel");

  // a nonzero stamp only on an accepted start
  a_stamp_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[TIME_W-1:0] != '0) |-> out_data_r[TIME_W])
    else $error("start stamp without an accepted start");

endmodule

// File: tb/timeout_timer_bank_tb.sv
`timescale 1ns / 100ps

module timeout_timer_bank_tb;
  import ttb_pkg::*;

  localparam int NUM_CH          = DEF_CHANNELS;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 24;
  localparam int STALL_LIMIT     = 3000;

  // register index that maps to nothing, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'hF;

  // one result transaction, laid out as out_tdata from the top bit down
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [MASK_W-1:0] map;
    logic              timed_out;
    logic              enabled;
    logic              accepted;
    logic [TIME_W-1:0] stamp;
  } timer_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed stimulus table
  typedef struct packed {
    row_kind_t             kind;
    op_t                   op;
    logic [CHAN_W-1:0]     ch;
    logic [TIME_W-1:0]     dur;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  typed;
    timer_result_t         want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [OP_W-1:0]       in_tuser  = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit hold_req = 1'b0;
  bit no_idle  = 1'b0;
  int mismatch_count = 0;

  timer_result_t pending_results[$];

  // shadow copy of the bank state and registers
  logic [TPU_W-1:0]  bank_tpu   = TPU_RESET;
  logic [MASK_W-1:0] bank_adm   = ADM_RESET;
  logic [TPU_W-1:0]  bank_phase = '0;
  logic [TIME_W-1:0] bank_now   = '0;
  logic              bank_on      [NUM_CH] = '{default: 1'b0};
  logic              bank_expired [NUM_CH] = '{default: 1'b0};
  logic [TIME_W-1:0] bank_begin   [NUM_CH] = '{default: '0};
  logic [TIME_W-1:0] bank_length  [NUM_CH] = '{default: '0};

  timeout_timer_bank dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_chan(input int c);
    bank_on[c]      = 1'b0;
    bank_expired[c] = 1'b0;
    bank_begin[c]   = '0;
    bank_length[c]  = '0;
  endfunction

  // advance the shadow bank by one operation and return its result
  function automatic timer_result_t timer_bank_step(input op_t op, input logic [CHAN_W-1:0] ch,
                                                    input logic [TIME_W-1:0] dur);
    timer_result_t     r;
    logic [TPU_W:0]    limit;
    logic [TPU_W:0]    next;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    case (op)
      OP_TICK: begin
        // prescaler, zero acts as one
        limit = (bank_tpu == '0) ? (TPU_W+1)'(1) : {1'b0, bank_tpu};
        next  = {1'b0, bank_phase} + 1'b1;
        if (next >= limit) begin
          bank_phase = '0;
          bank_now   = bank_now + 1'b1;
        end else begin
          bank_phase = next[TPU_W-1:0];
        end
        // expiry sweep with modular elapsed time
        for (int c = 0; c < NUM_CH; c++) begin
          elapsed = bank_now - bank_begin[c];
          if (bank_on[c] && !bank_expired[c] && elapsed >= bank_length[c]) begin
            if (bank_adm[c]) clear_chan(c);
            else bank_expired[c] = 1'b1;
          end
        end
      end
      OP_START: begin
        if (!bank_on[ch]) begin
          bank_on[ch]      = 1'b1;
          bank_length[ch]  = dur;
          bank_begin[ch]   = bank_now;
          bank_expired[ch] = 1'b0;
          r.stamp          = bank_now;
          r.accepted       = 1'b1;
        end
      end
      OP_DISABLE: clear_chan(ch);
      default: ;
    endcase
    r.enabled   = bank_on[ch];
    r.timed_out = bank_on[ch] && bank_expired[ch];
    for (int c = 0; c < NUM_CH; c++) r.map[c] = bank_on[c] && bank_expired[c];
    r.now = bank_now;
    return r;
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word);
    timer_result_t got;
    timer_result_t want;
    got = word[$bits(timer_result_t)-1:0];
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing pending", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.stamp !== want.stamp)
      report_mismatch($sformatf("start_stamp got %h want %h", got.stamp, want.stamp));
    if (got.accepted !== want.accepted)
      report_mismatch($sformatf("start_accepted got %b want %b", got.accepted, want.accepted));
    if (got.enabled !== want.enabled)
      report_mismatch($sformatf("chan_enabled got %b want %b", got.enabled, want.enabled));
    if (got.timed_out !== want.timed_out)
      report_mismatch($sformatf("chan_timed_out got %b want %b", got.timed_out, want.timed_out));
    if (got.map !== want.map)
      report_mismatch($sformatf("expired_map got %h want %h", got.map, want.map));
    if (got.now !== want.now)
      report_mismatch($sformatf("present_time got %h want %h", got.now, want.now));
  endtask

  // offer one input transaction, predict it once accepted; returns at a falling edge
  task automatic send_item(input op_t op, input logic [CHAN_W-1:0] ch,
                           input logic [TIME_W-1:0] dur, input logic typed,
                           input timer_result_t want);
    int            gap;
    timer_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {{(IN_DATA_W-CHAN_W-TIME_W){1'b0}}, dur, ch};
    do @(posedge clk); while (!in_tready);
    predicted = timer_bank_step(op, ch, dur);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // register write, issued at a falling edge while the bank is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TICKS_PER_UNIT) bank_tpu = val[TPU_W-1:0];
    else if (idx == REG_AUTO_DISABLE) bank_adm = val[MASK_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop offering and let every pending result drain
  task automatic settle_bank();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic stim_row_t item_row(input op_t op, input logic [CHAN_W-1:0] ch,
                                         input logic [TIME_W-1:0] dur);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.op   = op;
    r.ch   = ch;
    r.dur  = dur;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input op_t op, input logic [CHAN_W-1:0] ch,
                                            input logic [TIME_W-1:0] dur,
                                            input logic [TIME_W-1:0] stamp, input logic acc,
                                            input logic en, input logic tmo,
                                            input logic [MASK_W-1:0] map,
                                            input logic [TIME_W-1:0] now);
    stim_row_t r;
    r                = item_row(op, ch, dur);
    r.typed          = 1'b1;
    r.want.stamp     = stamp;
    r.want.accepted  = acc;
    r.want.enabled   = en;
    r.want.timed_out = tmo;
    r.want.map       = map;
    r.want.now       = now;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.op      = OP_TICK;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req   = 1'b0;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_tdata);
      @(negedge clk);
    end
  end

  // ends the run when no transaction moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL timeout_timer_bank");
    $finish;
  end

  initial begin : stimulus
    stim_row_t         rows[$];
    int                pick;
    op_t               op;
    logic [TIME_W-1:0] dur;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    rows.push_back(checked_row(OP_QUERY, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0));
    // start at time zero, stamp is zero but accepted
    rows.push_back(checked_row(OP_START, 3'd0, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 8'h00, 32'd0));
    // start on an enabled channel is refused
    rows.push_back(checked_row(OP_START, 3'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1, 1'b0, 8'h00,
                               32'd0));
    // zero prescale acts as one; zero duration expires on this tick
    rows.push_back(cfg_row(REG_TICKS_PER_UNIT, 10'd0));
    rows.push_back(checked_row(OP_TICK, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1, 1'b1, 8'h01, 32'd1));
    rows.push_back(checked_row(OP_START, 3'd7, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1, 1'b0, 8'h01,
                               32'd1));
    rows.push_back(item_row(OP_START, 3'd3, 32'd2));
    rows.push_back(item_row(OP_TICK, 3'd3, 32'd0));
    rows.push_back(item_row(OP_TICK, 3'd3, 32'hFFFF_FFFF));
    rows.push_back(item_row(OP_QUERY, 3'd7, 32'd0));
    rows.push_back(item_row(OP_DISABLE, 3'd0, 32'd0));
    // auto-clear on expiry
    rows.push_back(cfg_row(REG_AUTO_DISABLE, 10'h0FF));
    rows.push_back(item_row(OP_START, 3'd1, 32'd1));
    rows.push_back(item_row(OP_TICK, 3'd1, 32'd0));
    rows.push_back(cfg_row(REG_AUTO_DISABLE, 10'h000));
    // prescale lowered below the running phase
    rows.push_back(cfg_row(REG_TICKS_PER_UNIT, 10'd1000));
    rows.push_back(item_row(OP_TICK, 3'd5, 32'd0));
    rows.push_back(item_row(OP_TICK, 3'd5, 32'd0));
    rows.push_back(item_row(OP_TICK, 3'd5, 32'd0));
    rows.push_back(cfg_row(REG_TICKS_PER_UNIT, 10'd2));
    rows.push_back(item_row(OP_TICK, 3'd7, 32'd0));
    // unmapped register index is ignored
    rows.push_back(cfg_row(REG_NONE, 10'h3FF));
    rows.push_back(item_row(OP_QUERY, 3'd3, 32'd0));
    rows.push_back(item_row(OP_DISABLE, 3'd7, 32'd0));
    rows.push_back(item_row(OP_QUERY, 3'd2, 32'd0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle_bank();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].op, rows[i].ch, rows[i].dur, rows[i].typed, rows[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_bank();
      case (phase)
        0: begin
          write_reg(REG_TICKS_PER_UNIT, 10'd1);
          write_reg(REG_AUTO_DISABLE, 10'h000);
        end
        1: begin
          write_reg(REG_TICKS_PER_UNIT, 10'd0);
          write_reg(REG_AUTO_DISABLE, 10'h0FF);
        end
        2: begin
          write_reg(REG_TICKS_PER_UNIT, 10'd2);
          write_reg(REG_AUTO_DISABLE, {2'b00, 8'($urandom)});
        end
        3: begin
          write_reg(REG_TICKS_PER_UNIT, 10'd3);
          write_reg(REG_AUTO_DISABLE, 10'h000);
        end
        4: begin
          write_reg(REG_TICKS_PER_UNIT, 10'd1000);
          write_reg(REG_AUTO_DISABLE, {2'b00, 8'($urandom)});
        end
        5: begin
          write_reg(REG_TICKS_PER_UNIT, 10'($urandom_range(1, 5)));
          write_reg(REG_AUTO_DISABLE, 10'h055);
        end
        6: begin
          write_reg(REG_TICKS_PER_UNIT, 10'd1);
          write_reg(REG_AUTO_DISABLE, {2'b00, 8'($urandom)});
        end
        default: begin
          write_reg(REG_TICKS_PER_UNIT, 10'($urandom_range(1, 4)));
          write_reg(REG_AUTO_DISABLE, 10'h0FF);
        end
      endcase
      no_idle  = (phase == 3) || (phase == 6);
      hold_req = (phase == 1) || (phase == 5);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // half the items are ticks so channels actually run out
        pick = $urandom_range(0, 99);
        if (pick < 50) op = OP_TICK;
        else if (pick < 70) op = OP_START;
        else if (pick < 85) op = OP_QUERY;
        else op = OP_DISABLE;
        // short durations dominate, full range now and then
        pick = $urandom_range(0, 9);
        if (pick < 6) dur = $urandom_range(0, 6);
        else if (pick < 8) dur = $urandom_range(0, 40);
        else dur = $urandom();
        send_item(op, 3'($urandom_range(0, NUM_CH - 1)), dur, 1'b0, '0);
      end
    end

    settle_bank();
    if (mismatch_count == 0)
      $display("PASS timeout_timer_bank");
    else
      $display("FAIL timeout_timer_bank");
    $finish;
  end

endmodule
